### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion helpers for the rtl files
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// expr must hold at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (expr)) \
        else $error("assertion failed");
// expr must never hold at a clock edge out of reset
`define ASSERT_NEVER(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(expr)) \
        else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rstn, expr)
`define ASSERT_NEVER(lbl, clk, rstn, expr)
`endif
`endif

### rtl/qjtg_pkg.sv
// ----------------------------------------------------------------------------
// qjtg_pkg
// shared types, constants and arithmetic helpers of the trajectory generator
// ----------------------------------------------------------------------------
package qjtg_pkg;

    localparam int JOINT_W   = 3;
    localparam int POS_W     = 24;
    localparam int DELTA_W   = 25;
    localparam int DUR_W     = 20;
    localparam int RECIP_W   = 25;
    localparam int CFG_W     = 25;
    localparam int CFG_IDX_W = 1;
    localparam int Q_W       = 25;
    localparam int DS_W      = 26;
    localparam int MUL_W     = 27;
    localparam int PROD_W    = 2 * MUL_W;
    localparam int RND_W     = PROD_W - 24;
    localparam int MAX_SLOTS = 8;
    localparam int DEF_NUM_JOINTS = 8;

    localparam logic [DUR_W-1:0]   DUR_RESET   = 20'd200;
    localparam logic [RECIP_W-1:0] RECIP_RESET = 25'd83886;
    localparam logic [DUR_W-1:0]   ELAPSED_MAX = 20'hFFFFF;
    localparam logic [Q_W-1:0]     ONE_Q24     = 25'h1000000;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_DURATION = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_RECIP    = 1'b1;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TICK = 1'b1;

    typedef struct packed {
        logic                      is_tick;
        logic                      wr_en;
        logic                      arm;
        logic [JOINT_W-1:0]        joint;
        logic signed [POS_W-1:0]   start;
        logic signed [DELTA_W-1:0] delta;
    } cmd_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_TAU, ST_CLAMP, ST_P2, ST_P3, ST_P4, ST_P5,
        ST_POLY, ST_JS, ST_JD, ST_JV, ST_EMIT
    } state_t;

    // floor((x + 2^23) / 2^24)
    function automatic logic signed [RND_W-1:0] round24(input logic signed [PROD_W-1:0] x);
        logic signed [PROD_W-1:0] y;
        y = x + PROD_W'(64'sd8388608);
        return y[PROD_W-1:24];
    endfunction

    function automatic logic signed [POS_W-1:0] sat24(input logic signed [31:0] v);
        if (v > 32'sd8388607) begin
            return 24'sh7FFFFF;
        end else if (v < -32'sd8388608) begin
            return 24'sh800000;
        end
        return v[POS_W-1:0];
    endfunction

endpackage

### rtl/quintic_joint_trajectory_generator_unit.sv
// a tick steps through tau, clamp, the powers of tau and the polynomial, then per joint
// through position, velocity and emit; emit waits while the output register is busy
// products use the single shared 27x27 multiplier; the back takes items only while idle
// reset: aresetn synchronous active low clears state, endpoints and counters
// ----------------------------------------------------------------------------
// quintic_joint_trajectory_generator_unit
// minimum-jerk joint trajectory generator, front decode, queue and back datapath
// ----------------------------------------------------------------------------
module quintic_joint_trajectory_generator_unit #(
    parameter int NUM_JOINTS = qjtg_pkg::DEF_NUM_JOINTS
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // configuration write port
    input  logic                                cfg_wr_en,
    input  logic [qjtg_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [qjtg_pkg::CFG_W-1:0]          cfg_data,
    // input items
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_operation,
    input  logic [qjtg_pkg::JOINT_W-1:0]        s_joint,
    input  logic signed [qjtg_pkg::POS_W-1:0]   s_start_position,
    input  logic signed [qjtg_pkg::POS_W-1:0]   s_goal_position,
    input  logic                                s_arm,
    // result items
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [qjtg_pkg::JOINT_W-1:0]        m_joint_out,
    output logic signed [qjtg_pkg::POS_W-1:0]   m_position_command,
    output logic signed [qjtg_pkg::POS_W-1:0]   m_velocity_command,
    output logic                                m_finished,
    output logic                                m_last
);
    import qjtg_pkg::*;

    // configuration registers
    logic [DUR_W-1:0]   duration_reg;
    logic [RECIP_W-1:0] recip_reg;

    // queue between front and back
    cmd_t push_cmd, head_cmd;
    logic q_push, q_pop, q_full, q_empty;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            duration_reg <= DUR_RESET;
            recip_reg    <= RECIP_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_IDX_DURATION: duration_reg <= cfg_data[DUR_W-1:0];
                CFG_IDX_RECIP:    recip_reg    <= cfg_data[RECIP_W-1:0];
                default: ;
            endcase
        end
    end

    // front: accept and classify each item, form goal minus start
    qjtg_front #(.NUM_JOINTS(NUM_JOINTS)) u_front (
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_operation      (s_operation),
        .s_joint          (s_joint),
        .s_start_position (s_start_position),
        .s_goal_position  (s_goal_position),
        .s_arm            (s_arm),
        .q_full           (q_full),
        .q_push           (q_push),
        .q_cmd            (push_cmd)
    );

    // short queue lets the front keep taking items while a tick runs
    qjtg_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_cmd (push_cmd),
        .pop      (q_pop),
        .head_cmd (head_cmd),
        .full     (q_full),
        .empty    (q_empty)
    );

    // back: loads, tick counter, polynomial and per-joint scaling
    qjtg_back #(.NUM_JOINTS(NUM_JOINTS)) u_back (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .q_empty            (q_empty),
        .q_cmd              (head_cmd),
        .q_pop              (q_pop),
        .duration           (duration_reg),
        .recip              (recip_reg),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_joint_out        (m_joint_out),
        .m_position_command (m_position_command),
        .m_velocity_command (m_velocity_command),
        .m_finished         (m_finished),
        .m_last             (m_last)
    );

endmodule

### rtl/qjtg_front.sv
// ----------------------------------------------------------------------------
// qjtg_front
// accepts input items, classifies them and forms the endpoint delta
// ----------------------------------------------------------------------------
module qjtg_front #(
    parameter int NUM_JOINTS = qjtg_pkg::DEF_NUM_JOINTS
) (
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_operation,
    input  logic [qjtg_pkg::JOINT_W-1:0]        s_joint,
    input  logic signed [qjtg_pkg::POS_W-1:0]   s_start_position,
    input  logic signed [qjtg_pkg::POS_W-1:0]   s_goal_position,
    input  logic                                s_arm,
    input  logic                                q_full,
    output logic                                q_push,
    output qjtg_pkg::cmd_t                      q_cmd
);
    import qjtg_pkg::*;

    localparam int SLOTS = (NUM_JOINTS < MAX_SLOTS) ? NUM_JOINTS : MAX_SLOTS;
    localparam logic [JOINT_W:0] SLOTS_L = (JOINT_W + 1)'(SLOTS);

    assign s_ready = !q_full;
    assign q_push  = s_valid && !q_full;

    always_comb begin
        q_cmd.is_tick = (s_operation == OP_TICK);
        // loads to slots beyond the emitted range are dropped, arm still acts
        q_cmd.wr_en   = (s_operation == OP_LOAD) && ({1'b0, s_joint} < SLOTS_L);
        q_cmd.arm     = (s_operation == OP_LOAD) && s_arm;
        q_cmd.joint   = s_joint;
        q_cmd.start   = s_start_position;
        q_cmd.delta   = DELTA_W'(s_goal_position) - DELTA_W'(s_start_position);
    end

endmodule

### rtl/qjtg_fifo.sv
// ----------------------------------------------------------------------------
// qjtg_fifo
// two-entry command queue between the front and back parts
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module qjtg_fifo (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  qjtg_pkg::cmd_t push_cmd,
    input  logic           pop,
    output qjtg_pkg::cmd_t head_cmd,
    output logic           full,
    output logic           empty
);
    import qjtg_pkg::*;

    cmd_t       entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full     = (count_reg == 2'd2);
    assign empty    = (count_reg == 2'd0);
    assign head_cmd = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    `ASSERT_NEVER(a_pop_empty, aclk, aresetn, pop && empty)
    `ASSERT_NEVER(a_push_full, aclk, aresetn, push && full)
    `ASSERT_ALWAYS(a_count_range, aclk, aresetn, count_reg != 2'd3)

endmodule

### rtl/qjtg_back.sv
// ----------------------------------------------------------------------------
// qjtg_back
// executes loads and ticks: polynomial evaluation and per-joint scaling
// ----------------------------------------------------------------------------
module qjtg_back #(
    parameter int NUM_JOINTS = qjtg_pkg::DEF_NUM_JOINTS
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                q_empty,
    input  qjtg_pkg::cmd_t                      q_cmd,
    output logic                                q_pop,
    input  logic [qjtg_pkg::DUR_W-1:0]          duration,
    input  logic [qjtg_pkg::RECIP_W-1:0]        recip,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [qjtg_pkg::JOINT_W-1:0]        m_joint_out,
    output logic signed [qjtg_pkg::POS_W-1:0]   m_position_command,
    output logic signed [qjtg_pkg::POS_W-1:0]   m_velocity_command,
    output logic                                m_finished,
    output logic                                m_last
);
    import qjtg_pkg::*;

    localparam int SLOTS = (NUM_JOINTS < MAX_SLOTS) ? NUM_JOINTS : MAX_SLOTS;
    localparam int JW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [JW-1:0] LAST_J = JW'(SLOTS - 1);

    state_t state_reg, state_next;
    logic   active_reg, active_next;
    logic [DUR_W-1:0] elapsed_reg, elapsed_next;
    logic [Q_W-1:0]   tau_reg, tau_next;
    logic             done_reg, done_next;
    logic [Q_W-1:0]   t2_reg, t2_next, t3_reg, t3_next, t4_reg, t4_next;
    logic [Q_W-1:0]   s_reg, s_next;
    logic [DS_W-1:0]  ds_reg, ds_next;
    logic signed [POS_W-1:0]  pos_reg, pos_next;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic [JW-1:0]    j_reg, j_next;

    logic signed [POS_W-1:0]   start_reg [SLOTS];
    logic signed [DELTA_W-1:0] delta_reg [SLOTS];

    logic                      m_valid_reg, m_valid_next;
    logic [JOINT_W-1:0]        m_joint_reg, m_joint_next;
    logic signed [POS_W-1:0]   m_pos_reg, m_pos_next;
    logic signed [POS_W-1:0]   m_vel_reg, m_vel_next;
    logic                      m_fin_reg, m_fin_next;
    logic                      m_last_reg, m_last_next;

    logic signed [MUL_W-1:0]   mul_a, mul_b;
    logic signed [RND_W-1:0]   rnd;
    logic signed [31:0]        s_full, ds_full;
    logic signed [DELTA_W-1:0] d_cur;
    logic                      out_free;
    logic                      load_wr;

    assign rnd      = round24(prod_reg);
    assign d_cur    = delta_reg[j_reg];
    assign out_free = !m_valid_reg || m_ready;
    assign q_pop    = (state_reg == ST_IDLE) && !q_empty;
    assign load_wr  = q_pop && !q_cmd.is_tick && q_cmd.wr_en;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (q_pop && q_cmd.is_tick && active_reg) state_next = ST_TAU;
            ST_TAU:   state_next = ST_CLAMP;
            ST_CLAMP: state_next = ST_P2;
            ST_P2:    state_next = ST_P3;
            ST_P3:    state_next = ST_P4;
            ST_P4:    state_next = ST_P5;
            ST_P5:    state_next = ST_POLY;
            ST_POLY:  state_next = ST_JS;
            ST_JS:    state_next = ST_JD;
            ST_JD:    state_next = ST_JV;
            ST_JV:    state_next = ST_EMIT;
            ST_EMIT: begin
                if (out_free) state_next = (j_reg == LAST_J) ? ST_IDLE : ST_JS;
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // datapath
    always_comb begin
        active_next  = active_reg;
        elapsed_next = elapsed_reg;
        tau_next     = tau_reg;
        done_next    = done_reg;
        t2_next      = t2_reg;
        t3_next      = t3_reg;
        t4_next      = t4_reg;
        s_next       = s_reg;
        ds_next      = ds_reg;
        pos_next     = pos_reg;
        j_next       = j_reg;
        mul_a        = '0;
        mul_b        = '0;
        s_full       = '0;
        ds_full      = '0;
        m_valid_next = m_valid_reg && !m_ready;
        m_joint_next = m_joint_reg;
        m_pos_next   = m_pos_reg;
        m_vel_next   = m_vel_reg;
        m_fin_next   = m_fin_reg;
        m_last_next  = m_last_reg;
        case (state_reg)
            ST_IDLE: begin
                if (q_pop) begin
                    if (q_cmd.is_tick) begin
                        if (active_reg && elapsed_reg != ELAPSED_MAX) begin
                            elapsed_next = elapsed_reg + 1'b1;
                        end
                    end else if (q_cmd.arm) begin
                        active_next  = 1'b1;
                        elapsed_next = '0;
                    end
                end
            end
            ST_TAU: begin
                mul_a = MUL_W'(elapsed_reg);
                mul_b = MUL_W'(recip);
            end
            ST_CLAMP: begin
                done_next = (elapsed_reg >= duration) || (prod_reg >= PROD_W'(ONE_Q24));
                tau_next  = done_next ? ONE_Q24 : prod_reg[Q_W-1:0];
            end
            ST_P2: begin
                mul_a = MUL_W'(tau_reg);
                mul_b = MUL_W'(tau_reg);
            end
            ST_P3: begin
                t2_next = rnd[Q_W-1:0];
                mul_a   = MUL_W'(rnd[Q_W-1:0]);
                mul_b   = MUL_W'(tau_reg);
            end
            ST_P4: begin
                t3_next = rnd[Q_W-1:0];
                mul_a   = MUL_W'(rnd[Q_W-1:0]);
                mul_b   = MUL_W'(tau_reg);
            end
            ST_P5: begin
                t4_next = rnd[Q_W-1:0];
                mul_a   = MUL_W'(rnd[Q_W-1:0]);
                mul_b   = MUL_W'(tau_reg);
            end
            ST_POLY: begin
                s_full = 32'sd10 * $signed(32'(t3_reg)) - 32'sd15 * $signed(32'(t4_reg))
                       + 32'sd6 * $signed(32'(rnd[Q_W-1:0]));
                ds_full = 32'sd30 * $signed(32'(t2_reg)) - 32'sd60 * $signed(32'(t3_reg))
                        + 32'sd30 * $signed(32'(t4_reg));
                if (s_full < 0) begin
                    s_next = '0;
                end else if (s_full > $signed(32'(ONE_Q24))) begin
                    s_next = ONE_Q24;
                end else begin
                    s_next = s_full[Q_W-1:0];
                end
                ds_next = (ds_full < 0) ? '0 : ds_full[DS_W-1:0];
                j_next  = '0;
            end
            ST_JS: begin
                mul_a = MUL_W'(s_reg);
                mul_b = MUL_W'(d_cur);
            end
            ST_JD: begin
                pos_next = sat24(32'(start_reg[j_reg]) + 32'(rnd));
                mul_a    = MUL_W'(ds_reg);
                mul_b    = MUL_W'(d_cur);
            end
            ST_JV: begin
                mul_a = rnd[MUL_W-1:0];
                mul_b = MUL_W'(recip);
            end
            ST_EMIT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_joint_next = JOINT_W'(j_reg);
                    m_pos_next   = pos_reg;
                    m_vel_next   = sat24(32'(rnd));
                    m_fin_next   = done_reg;
                    m_last_next  = (j_reg == LAST_J);
                    j_next       = j_reg + 1'b1;
                    if (j_reg == LAST_J && done_reg) active_next = 1'b0;
                end
            end
            default: ;
        endcase
        prod_next = mul_a * mul_b;
        // keep the velocity product while the output register is busy
        if (state_reg == ST_EMIT && !out_free) begin
            prod_next = prod_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            active_reg  <= 1'b0;
            elapsed_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            active_reg  <= active_next;
            elapsed_reg <= elapsed_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        tau_reg     <= tau_next;
        done_reg    <= done_next;
        t2_reg      <= t2_next;
        t3_reg      <= t3_next;
        t4_reg      <= t4_next;
        s_reg       <= s_next;
        ds_reg      <= ds_next;
        pos_reg     <= pos_next;
        prod_reg    <= prod_next;
        j_reg       <= j_next;
        m_joint_reg <= m_joint_next;
        m_pos_reg   <= m_pos_next;
        m_vel_reg   <= m_vel_next;
        m_fin_reg   <= m_fin_next;
        m_last_reg  <= m_last_next;
    end

    // joint endpoint store, cleared by reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < SLOTS; i++) begin
                start_reg[i] <= '0;
                delta_reg[i] <= '0;
            end
        end else if (load_wr) begin
            start_reg[q_cmd.joint[JW-1:0]] <= q_cmd.start;
            delta_reg[q_cmd.joint[JW-1:0]] <= q_cmd.delta;
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_joint_out        = m_joint_reg;
    assign m_position_command = m_pos_reg;
    assign m_velocity_command = m_vel_reg;
    assign m_finished         = m_fin_reg;
    assign m_last             = m_last_reg;

endmodule

### bench/quintic_joint_trajectory_generator_unit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// quintic_joint_trajectory_generator_unit_test
// drives load and tick items through the trajectory generator under several
// duration settings, predicts every joint command in fixed point and checks
// each result item in order, with random idling and back pressure
// ----------------------------------------------------------------------------
module quintic_joint_trajectory_generator_unit_test;
    import qjtg_pkg::*;

    localparam int SLOTS = 8;

    logic                      aclk;
    logic                      aresetn;
    logic                      cfg_wr_en;
    logic [CFG_IDX_W-1:0]      cfg_index;
    logic [CFG_W-1:0]          cfg_data;
    logic                      s_valid;
    logic                      s_ready;
    logic                      s_operation;
    logic [JOINT_W-1:0]        s_joint;
    logic signed [POS_W-1:0]   s_start_position;
    logic signed [POS_W-1:0]   s_goal_position;
    logic                      s_arm;
    logic                      m_valid;
    logic                      m_ready;
    logic [JOINT_W-1:0]        m_joint_out;
    logic signed [POS_W-1:0]   m_position_command;
    logic signed [POS_W-1:0]   m_velocity_command;
    logic                      m_finished;
    logic                      m_last;

    typedef struct packed {
        logic [JOINT_W-1:0]      joint;
        logic signed [POS_W-1:0] pos;
        logic signed [POS_W-1:0] vel;
        logic                    finished;
        logic                    last;
    } joint_command_t;

    // predicts the joint commands of each tick and checks them in order
    class trajectory_scoreboard;
        logic [DUR_W-1:0]   duration;
        logic [RECIP_W-1:0] recip;
        longint             start_pos[SLOTS];
        longint             delta[SLOTS];
        longint             elapsed;
        bit                 running;
        joint_command_t     commands[$];
        int                 errors;

        function new();
            duration = DUR_RESET;
            recip    = RECIP_RESET;
            foreach (start_pos[i]) begin
                start_pos[i] = 0;
                delta[i]     = 0;
            end
            elapsed = 0;
            running = 0;
            errors  = 0;
        endfunction

        function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] v);
            if (idx == CFG_IDX_DURATION) begin
                duration = v[DUR_W-1:0];
            end else begin
                recip = v[RECIP_W-1:0];
            end
        endfunction

        function longint rnd24(longint x);
            return (x + (64'sd1 <<< 23)) >>> 24;
        endfunction

        function longint qmul(longint a, longint b);
            return (a * b + (64'sd1 <<< 23)) >>> 24;
        endfunction

        function logic signed [POS_W-1:0] clip24(longint v);
            if (v > 8388607) begin
                return 24'sh7FFFFF;
            end else if (v < -8388608) begin
                return 24'sh800000;
            end
            return v[POS_W-1:0];
        endfunction

        function void note_item(logic op, logic [JOINT_W-1:0] j,
                                logic signed [POS_W-1:0] st, logic signed [POS_W-1:0] gl,
                                logic arm);
            longint tau, t2, t3, t4, t5, s, ds, v1;
            bit done;
            joint_command_t c;
            if (op == OP_LOAD) begin
                start_pos[j] = longint'(st);
                delta[j]     = longint'(gl) - longint'(st);
                if (arm) begin
                    running = 1;
                    elapsed = 0;
                end
                return;
            end
            if (!running) return;
            if (elapsed < longint'(ELAPSED_MAX)) elapsed++;
            tau  = elapsed * longint'(recip);
            done = 0;
            if (elapsed >= longint'(duration) || tau >= (64'sd1 <<< 24)) begin
                tau  = 64'sd1 <<< 24;
                done = 1;
            end
            t2 = qmul(tau, tau);
            t3 = qmul(t2, tau);
            t4 = qmul(t3, tau);
            t5 = qmul(t4, tau);
            s  = 10 * t3 - 15 * t4 + 6 * t5;
            if (s < 0) s = 0;
            if (s > (64'sd1 <<< 24)) s = 64'sd1 <<< 24;
            ds = 30 * t2 - 60 * t3 + 30 * t4;
            if (ds < 0) ds = 0;
            for (int k = 0; k < SLOTS; k++) begin
                v1         = rnd24(ds * delta[k]);
                c.joint    = k[JOINT_W-1:0];
                c.pos      = clip24(start_pos[k] + rnd24(s * delta[k]));
                c.vel      = clip24(rnd24(v1 * longint'(recip)));
                c.finished = done;
                c.last     = (k == SLOTS - 1);
                commands   = {commands, c};
            end
            if (done) running = 0;
        endfunction

        function void check_result(joint_command_t got);
            joint_command_t want;
            if (commands.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result: joint %0d", got.joint);
                return;
            end
            want = commands.pop_front();
            if (got !== want) begin
                errors++;
                if (errors <= 10) begin
                    $display("mismatch exp j%0d p%0d v%0d f%0b l%0b got j%0d p%0d v%0d f%0b l%0b",
                             want.joint, want.pos, want.vel, want.finished, want.last,
                             got.joint, got.pos, got.vel, got.finished, got.last);
                end
            end
        endfunction
    endclass

    trajectory_scoreboard board;
    bit steady;        // no idling on either side while set
    int results_seen;
    joint_command_t got;

    quintic_joint_trajectory_generator_unit u_dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_wr_en          (cfg_wr_en),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_operation        (s_operation),
        .s_joint            (s_joint),
        .s_start_position   (s_start_position),
        .s_goal_position    (s_goal_position),
        .s_arm              (s_arm),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_joint_out        (m_joint_out),
        .m_position_command (m_position_command),
        .m_velocity_command (m_velocity_command),
        .m_finished         (m_finished),
        .m_last             (m_last)
    );

    // 12 ns clock
    initial aclk = 1'b0;
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // hang guard
    initial begin
        #20ms;
        $display("quintic_joint_trajectory_generator_unit_test NOT OK");
        $finish;
    end

    // result side: random stalls plus one long hold-off to fill the block
    initial begin
        int hold;
        bit held_once;
        hold      = 0;
        held_once = 0;
        results_seen = 0;
        m_ready   = 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                got.joint    = m_joint_out;
                got.pos      = m_position_command;
                got.vel      = m_velocity_command;
                got.finished = m_finished;
                got.last     = m_last;
                board.check_result(got);
                results_seen++;
            end
            if (!held_once && results_seen == 40) begin
                held_once = 1;
                hold      = 700;
            end
            if (hold > 0) begin
                hold--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= steady || ($urandom_range(99) >= 28);
            end
        end
    end

    // offer one item and hold it until accepted
    task automatic send_item(logic op, logic [JOINT_W-1:0] j,
                             logic signed [POS_W-1:0] st, logic signed [POS_W-1:0] gl,
                             logic arm);
        if (!steady && $urandom_range(99) < 28) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge aclk);
        end
        s_valid          <= 1'b1;
        s_operation      <= op;
        s_joint          <= j;
        s_start_position <= st;
        s_goal_position  <= gl;
        s_arm            <= arm;
        do @(posedge aclk); while (!s_ready);
        board.note_item(op, j, st, gl, arm);
    endtask

    task automatic send_tick();
        send_item(OP_TICK, JOINT_W'($urandom), POS_W'($urandom), POS_W'($urandom),
                  1'($urandom));
    endtask

    // let every expected command drain, plus slack for a load in flight
    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (board.commands.size() != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] v);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(posedge aclk);
        board.write_register(idx, v);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    // mostly full load sequences followed by ticks, some loose items
    task automatic random_items(int count);
        int sent, nload, nticks;
        sent = 0;
        while (sent < count) begin
            if ($urandom_range(99) < 75) begin
                nload = $urandom_range(1, SLOTS);
                for (int k = 0; k < nload; k++) begin
                    send_item(OP_LOAD, (nload == SLOTS) ? JOINT_W'(k) : JOINT_W'($urandom),
                              POS_W'($urandom), POS_W'($urandom), k == nload - 1);
                end
                nticks = $urandom_range(1, 8);
                for (int k = 0; k < nticks; k++) send_tick();
                sent += nload + nticks;
            end else begin
                send_item(1'($urandom), JOINT_W'($urandom), POS_W'($urandom),
                          POS_W'($urandom), ($urandom_range(99) < 20));
                sent++;
            end
        end
    endtask

    initial begin
        logic [DUR_W-1:0]   durations[5];
        logic [RECIP_W-1:0] recips[5];
        board = new();
        steady           = 0;
        aresetn          = 1'b0;
        cfg_wr_en        = 1'b0;
        cfg_index        = CFG_IDX_DURATION;
        cfg_data         = '0;
        s_valid          = 1'b0;
        s_operation      = OP_LOAD;
        s_joint          = '0;
        s_start_position = '0;
        s_goal_position  = '0;
        s_arm            = 1'b0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: idle tick, extreme endpoints, arm, ticks, load mid-run
        send_tick();
        send_item(OP_LOAD, 3'd0, 24'sh7FFFFF, 24'sh800000, 1'b0);
        send_item(OP_LOAD, 3'd1, 24'sh800000, 24'sh7FFFFF, 1'b0);
        send_item(OP_LOAD, 3'd2, 24'sh000000, 24'sh7FFFFF, 1'b0);
        send_item(OP_LOAD, 3'd3, 24'sh7FFFFF, 24'sh7FFFFF, 1'b0);
        send_item(OP_LOAD, 3'd4, 24'sh800000, 24'sh000000, 1'b0);
        send_item(OP_LOAD, 3'd5, -24'sd1, 24'sd1, 1'b0);
        send_item(OP_LOAD, 3'd6, 24'sh555555, 24'shAAAAAA, 1'b0);
        send_item(OP_LOAD, 3'd7, 24'shAAAAAA, 24'sh555555, 1'b1);
        repeat (3) send_tick();
        send_item(OP_LOAD, 3'd2, 24'sh100000, -24'sh100000, 1'b0);
        repeat (2) send_tick();
        send_item(OP_LOAD, 3'd5, 24'sd7, 24'sd9, 1'b1);
        repeat (2) send_tick();
        settle();

        // settings: shortest, short exact, short with product reaching one,
        // longest with smallest reciprocal, mid range
        durations = '{20'd1, 20'd3, 20'd100, 20'hFFFFF, 20'd6};
        recips    = '{25'h1000000, 25'd5592405, 25'd4194304, 25'd16, 25'd2796203};
        random_items(80);
        for (int p = 0; p < 5; p++) begin
            settle();
            write_register(CFG_IDX_DURATION, CFG_W'(durations[p]));
            write_register(CFG_IDX_RECIP, CFG_W'(recips[p]));
            steady = (p == 2);
            // tick on the just-finished or idle trajectory before rearming
            send_tick();
            random_items(60);
        end
        steady = 0;
        settle();
        repeat (40) @(posedge aclk);

        if (board.errors == 0 && board.commands.size() == 0) begin
            $display("quintic_joint_trajectory_generator_unit_test OK");
        end else begin
            $display("quintic_joint_trajectory_generator_unit_test NOT OK");
        end
        $finish;
    end

endmodule
